// File: hdl/zlpf_pkg.sv
`timescale 1ns / 1ps

package zlpf_pkg;

  // Default build of the block.
  localparam int ZONES_DEF      = 12;
  localparam int FULL_SCALE_DEF = 100;

  // Fixed field widths.
  localparam int KIND_W  = 2;
  localparam int ZONE_W  = 4;
  localparam int COLOR_W = 2;
  localparam int LEVEL_W = 7;
  localparam int PINS_W  = 36;

  // Channels per zone: red, green, blue.
  localparam int COLORS = 3;

  // Item kinds.
  localparam logic [KIND_W-1:0] KIND_REFRESH = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DUTY    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SET     = 2'd2;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [ZONE_W-1:0]  zone;
    logic [COLOR_W-1:0] color;
    logic [LEVEL_W-1:0] level;
  } in_item_t;

  typedef struct packed {
    logic [PINS_W-1:0] led_pins;
    logic [ZONE_W-1:0] active_zone;
  } out_item_t;

  // Per-channel control decoded from one item.
  typedef struct packed {
    logic               refresh;
    logic               duty;
    logic               set;
    logic [LEVEL_W-1:0] level;
  } chan_ctl_t;

endpackage

// File: hdl/zlpf_chan.sv
`timescale 1ns / 1ps

module zlpf_chan #(
  parameter int FULL_SCALE = zlpf_pkg::FULL_SCALE_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                upd,
  input  zlpf_pkg::chan_ctl_t ctl,
  output logic                pin_nxt
);

  localparam logic [zlpf_pkg::LEVEL_W-1:0] FS = zlpf_pkg::LEVEL_W'(FULL_SCALE);

  logic                         pin_r;
  logic [zlpf_pkg::LEVEL_W-1:0] duty_r, duty_nxt;
  logic [zlpf_pkg::LEVEL_W-1:0] fade_r, fade_nxt;
  logic [zlpf_pkg::LEVEL_W-1:0] target_r, target_nxt;

  always_comb begin
    pin_nxt    = pin_r;
    duty_nxt   = duty_r;
    fade_nxt   = fade_r;
    target_nxt = target_r;
    if (ctl.refresh) begin
      // Restart the period at the current fade level, then move the fade one step.
      pin_nxt  = 1'b0;
      duty_nxt = fade_r;
      if (target_r > fade_r) begin
        fade_nxt = fade_r + 1'b1;
      end else if (target_r < fade_r) begin
        fade_nxt = fade_r - 1'b1;
      end
    end
    if (ctl.duty && !pin_r) begin
      if (duty_r >= FS) begin
        pin_nxt = 1'b1;
      end else begin
        duty_nxt = duty_r + 1'b1;
      end
    end
    if (ctl.set) begin
      target_nxt = ctl.level;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pin_r    <= 1'b0;
      duty_r   <= '0;
      fade_r   <= '0;
      target_r <= '0;
    end else if (upd) begin
      pin_r    <= pin_nxt;
      duty_r   <= duty_nxt;
      fade_r   <= fade_nxt;
      target_r <= target_nxt;
    end
  end

endmodule

// File: hdl/zone_led_pwm_with_fade_top.sv
`timescale 1ns / 1ps

// Channel   Ports                          Item
// -------   ----------------------------   -----------------------------------
// input     in_valid, in_stall, in_data    kind, zone, color, level
// result    out_valid, out_stall, out_data led_pins, active_zone
//
// One item is accepted per cycle while in_stall is low; its result is registered.
// All channel state sits in per-channel registers that update in the accept cycle,
// so the single result register plus one skid entry set the pace, not the work.
// Synchronous active-low reset clears all channel state, the zone pointer and both
// valid flags; no clearing pass is needed.
// A stalled result is held; one more item is taken into the skid entry, after which
// in_stall rises until the result side drains.

module zone_led_pwm_with_fade_top #(
  parameter int ZONES      = zlpf_pkg::ZONES_DEF,
  parameter int FULL_SCALE = zlpf_pkg::FULL_SCALE_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  zlpf_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output zlpf_pkg::out_item_t out_data
);

  localparam int CHANNELS = ZONES * zlpf_pkg::COLORS;
  localparam logic [zlpf_pkg::ZONE_W-1:0]  LAST_ZONE = zlpf_pkg::ZONE_W'(ZONES - 1);
  localparam logic [zlpf_pkg::LEVEL_W-1:0] FS        = zlpf_pkg::LEVEL_W'(FULL_SCALE);

  logic                         acc;
  logic                         out_fire, out_free;
  logic                         is_refresh, is_duty, is_set;
  logic [zlpf_pkg::ZONE_W-1:0]  zone_ptr_r, zone_ptr_nxt;
  logic [zlpf_pkg::LEVEL_W-1:0] level_sat;
  logic [CHANNELS-1:0]          pin_nxt;
  logic [zlpf_pkg::PINS_W-1:0]  pins;
  zlpf_pkg::out_item_t          res;
  logic                         out_valid_r, skid_valid_r;
  zlpf_pkg::out_item_t          out_data_r, skid_data_r;

  assign acc      = in_valid && !skid_valid_r;
  assign in_stall = skid_valid_r;

  assign is_refresh = (in_data.kind == zlpf_pkg::KIND_REFRESH);
  assign is_duty    = (in_data.kind == zlpf_pkg::KIND_DUTY);
  assign is_set     = (in_data.kind == zlpf_pkg::KIND_SET);

  // Pointer wraps to zone zero after the last zone.
  always_comb begin
    zone_ptr_nxt = zone_ptr_r;
    if (is_refresh) begin
      if (zone_ptr_r >= LAST_ZONE) begin
        zone_ptr_nxt = '0;
      end else begin
        zone_ptr_nxt = zone_ptr_r + 1'b1;
      end
    end
  end

  // Targets saturate at full scale.
  assign level_sat = (in_data.level > FS) ? FS : in_data.level;

  // One lane per channel. Out-of-range zones or a color of three match no lane,
  // so such a set-target item changes nothing.
  for (genvar z = 0; z < ZONES; z++) begin : g_zone
    for (genvar c = 0; c < zlpf_pkg::COLORS; c++) begin : g_color
      zlpf_pkg::chan_ctl_t ctl;

      assign ctl.refresh = is_refresh && (zone_ptr_nxt == zlpf_pkg::ZONE_W'(z));
      assign ctl.duty    = is_duty;
      assign ctl.set     = is_set && (in_data.zone == zlpf_pkg::ZONE_W'(z))
                           && (in_data.color == zlpf_pkg::COLOR_W'(c));
      assign ctl.level   = level_sat;

      zlpf_chan #(
        .FULL_SCALE(FULL_SCALE)
      ) u_chan (
        .clk    (clk),
        .rst_n  (rst_n),
        .upd    (acc),
        .ctl    (ctl),
        .pin_nxt(pin_nxt[z*zlpf_pkg::COLORS+c])
      );
    end
  end

  // Channels beyond the pin vector are dropped; missing ones read as off.
  for (genvar b = 0; b < zlpf_pkg::PINS_W; b++) begin : g_pin
    if (b < CHANNELS) begin : g_used
      assign pins[b] = pin_nxt[b];
    end else begin : g_unused
      assign pins[b] = 1'b0;
    end
  end

  assign res.led_pins    = pins;
  assign res.active_zone = zone_ptr_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zone_ptr_r <= '0;
    end else if (acc) begin
      zone_ptr_r <= zone_ptr_nxt;
    end
  end

  // Result register with one skid entry behind it.
  assign out_fire = out_valid_r && !out_stall;
  assign out_free = !out_valid_r || out_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= acc;
      end
    end else if (acc) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid_r) begin
        out_data_r <= skid_data_r;
      end else if (acc) begin
        out_data_r <= res;
      end
    end else if (acc) begin
      skid_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: hdl/zlpf_check.sv
`timescale 1ns / 1ps

module zlpf_check #(
  parameter int ZONES = zlpf_pkg::ZONES_DEF
) (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input zlpf_pkg::out_item_t out_data
);

  // A held result stays valid.
  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // A held result keeps its payload.
  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_data))
    else $error("stalled result changed");

  // Input back-pressure only while a result is waiting.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with no result pending");

  // Every accepted item leaves a result pending on the next cycle.
  a_accept_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> out_valid)
    else $error("accepted item produced no result");

  // The reported zone is always a real zone.
  a_zone_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (int'(out_data.active_zone) < ZONES))
    else $error("active zone out of range");

endmodule

bind zone_led_pwm_with_fade_top zlpf_check #(.ZONES(ZONES)) u_zlpf_check (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_stall (in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_data (out_data)
);
